[sv/pstate_load_governor_unit_defines.svh]
// Assertion helpers shared by the governor RTL.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef PSTATE_LOAD_GOVERNOR_UNIT_DEFINES_SVH
`define PSTATE_LOAD_GOVERNOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PLG_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("governor assertion failed");

// Next-cycle implication.
`define PLG_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("governor assertion failed");

`endif

[sv/plg_pkg.sv]
package plg_pkg;

  localparam int PLG_NUM_PSTATES = 16;

  localparam int ST_W      = 4;
  localparam int PCT_W     = 7;
  localparam int CNT_W     = 32;
  localparam int USAGE_W   = 32;
  localparam int NUM_CNT   = 5;
  localparam int IDLE_SLOT = 4;
  localparam int CNT_IDX_W = 3;
  // Five 32-bit deltas sum into 35 bits; idle delta times 100 needs 39.
  localparam int SUM_W     = 35;
  localparam int PROD_W    = 39;
  localparam int DIV_W     = SUM_W + PCT_W - 1;
  localparam int STEP_W    = 3;

  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD    = 4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef logic [ST_W-1:0]  pstate_t;
  typedef logic [PCT_W-1:0] pct_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam pct_t PERCENT = 7'd100;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OUTCOME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_AUTO_ENABLE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIXED_STATE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGHEST_STATE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOWEST_STATE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RAISE_THRESHOLD = 3'd4;

  localparam logic    AUTO_RST    = 1'b1;
  localparam pstate_t FIXED_RST   = 4'd0;
  localparam pstate_t HIGHEST_RST = 4'd0;
  localparam pstate_t LOWEST_RST  = 4'd15;
  localparam pct_t    RAISE_RST   = 7'd98;

endpackage

[sv/plg_ram.sv]
module plg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/plg_busy_div.sv]
module plg_busy_div import plg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [SUM_W-1:0]  den,
  output logic              done,
  output pct_t              quot
);

  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsh_r, dsh_nxt;
  pct_t              q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W-1:0]  rem_ext;
  logic              fits;

  // Restoring division, one quotient bit per cycle. The quotient never
  // exceeds 100 because the idle delta is part of the sum.
  always_comb begin
    rem_ext  = DIV_W'(rem_r);
    fits     = rem_ext >= dsh_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(PCT_W-1){1'b0}}};
      q_nxt    = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = rem_r - PROD_W'(dsh_r);
      end
      q_nxt    = {q_r[PCT_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(PCT_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[sv/pstate_load_governor_unit.sv]
// Performance-state governor. Every request on the in_ stream returns exactly one
// result on the out_ stream, in order, one request in flight at a time; a new request
// is taken as soon as the previous result sits in the output register, and a request
// waits in its last step while that register still holds a result not yet taken. A
// load-driven tick goes through the counter deltas, a sum of the five deltas through a
// single adder, one multiply, the seven-step restoring divider, then the decision, the
// read and the write-back of the usage counter in its RAM, and the output load. A
// snapshot tick or a fixed-mode tick skips the sum and divide. Outcome, threshold load
// and usage read requests go from their handling straight to the output load.
// Thresholds and usage counters live in single-port-read RAMs with one valid bit per
// entry, so they read as zero after reset without a clearing pass.
`include "pstate_load_governor_unit_defines.svh"

module pstate_load_governor_unit import plg_pkg::*; #(
  parameter int NUM_PSTATES = PLG_NUM_PSTATES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cnt_user, cnt_nice, cnt_system, cnt_interrupt, cnt_idle, transit_ok,
  // entry_index, entry_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // target_state, change_request, busy_percent, usage_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW      = $clog2(NUM_PSTATES);
  localparam int STATE_W = 4;

  localparam logic [STATE_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] ST_MISC   = 4'd1;
  localparam logic [STATE_W-1:0] ST_DELTA  = 4'd2;
  localparam logic [STATE_W-1:0] ST_SUM    = 4'd3;
  localparam logic [STATE_W-1:0] ST_MUL    = 4'd4;
  localparam logic [STATE_W-1:0] ST_DIV    = 4'd5;
  localparam logic [STATE_W-1:0] ST_DECIDE = 4'd6;
  localparam logic [STATE_W-1:0] ST_URD    = 4'd7;
  localparam logic [STATE_W-1:0] ST_UWR    = 4'd8;
  localparam logic [STATE_W-1:0] ST_OUT    = 4'd9;

  function automatic logic in_range(input pstate_t s);
    return 32'(s) < NUM_PSTATES;
  endfunction

  function automatic logic pending_pstate_ok(input pstate_t pend, input pstate_t cur);
    return pend != cur;
  endfunction

  // Configuration registers.
  logic    auto_r;
  pstate_t fixed_r, highest_r, lowest_r;
  pct_t    raise_r;
  logic    cfg_wr;

  // Control state.
  logic [STATE_W-1:0]   state_r, state_nxt;
  logic                 snapshot_valid_r, snapshot_valid_nxt;
  pstate_t              current_r, current_nxt;
  pstate_t              pending_r, pending_nxt;
  logic                 pending_valid_r, pending_valid_nxt;
  logic [NUM_PSTATES-1:0] thr_vld_r, thr_vld_nxt;
  logic [NUM_PSTATES-1:0] use_vld_r, use_vld_nxt;
  logic [CNT_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Request and working registers.
  logic [MODE_W-1:0]    mode_r;
  cnt_t                 now_r   [NUM_CNT];
  cnt_t                 prev_r  [NUM_CNT];
  cnt_t                 delta_r [NUM_CNT];
  logic                 ok_r;
  pstate_t              idx_r;
  pct_t                 val_r;
  logic [SUM_W-1:0]     acc_r;
  pct_t                 busy_r;
  logic                 snap_r;
  pstate_t              st_r;
  logic                 change_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic              in_accept;
  logic              out_load;
  logic              thr_we, thr_re, use_we, use_re;
  logic [AW-1:0]     use_raddr;
  logic [USAGE_W-1:0] use_wdata, use_rdata, usage_rd;
  pct_t              thr_rdata, thr_cur;
  logic              div_start, div_done;
  pct_t              div_q;
  logic [PROD_W-1:0] idle_prod;
  pstate_t           cand, step_st;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r    <= AUTO_RST;
      fixed_r   <= FIXED_RST;
      highest_r <= HIGHEST_RST;
      lowest_r  <= LOWEST_RST;
      raise_r   <= RAISE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[CFG_ADDR_W-1:2])
        REG_AUTO_ENABLE:     auto_r    <= cfg_pwdata[0];
        REG_FIXED_STATE:     fixed_r   <= cfg_pwdata[ST_W-1:0];
        REG_HIGHEST_STATE:   highest_r <= cfg_pwdata[ST_W-1:0];
        REG_LOWEST_STATE:    lowest_r  <= cfg_pwdata[ST_W-1:0];
        REG_RAISE_THRESHOLD: raise_r   <= cfg_pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[CFG_ADDR_W-1:2])
      REG_AUTO_ENABLE:     cfg_prdata = CFG_DATA_W'(auto_r);
      REG_FIXED_STATE:     cfg_prdata = CFG_DATA_W'(fixed_r);
      REG_HIGHEST_STATE:   cfg_prdata = CFG_DATA_W'(highest_r);
      REG_LOWEST_STATE:    cfg_prdata = CFG_DATA_W'(lowest_r);
      REG_RAISE_THRESHOLD: cfg_prdata = CFG_DATA_W'(raise_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- memories
  plg_ram #(.WIDTH(PCT_W), .DEPTH(NUM_PSTATES)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (AW'(idx_r)),
    .wdata (val_r),
    .re    (thr_re),
    .raddr (AW'(current_r)),
    .rdata (thr_rdata)
  );

  plg_ram #(.WIDTH(USAGE_W), .DEPTH(NUM_PSTATES)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (AW'(st_r)),
    .wdata (use_wdata),
    .re    (use_re),
    .raddr (use_raddr),
    .rdata (use_rdata)
  );

  // ---------------------------------------------------------- busy divide
  assign idle_prod = PROD_W'(delta_r[IDLE_SLOT]) * PROD_W'(PERCENT);

  plg_busy_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (idle_prod),
    .den   (acc_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // ------------------------------------------------------------- decision
  always_comb begin
    thr_cur = (in_range(current_r) && thr_vld_r[AW'(current_r)]) ? thr_rdata : '0;
    cand    = current_r;
    if (!snap_r) begin
      if (auto_r) begin
        if (busy_r > raise_r) begin
          if (cand > highest_r) begin
            cand = cand - ST_W'(1);
          end
        end else if (cand < lowest_r) begin
          if (busy_r <= thr_cur) begin
            cand = cand + ST_W'(1);
          end
        end
      end else begin
        cand = fixed_r;
      end
    end
    if (cand < highest_r) begin
      cand = highest_r;
    end
    // The state moves at most one step per tick.
    if (cand < current_r) begin
      step_st = current_r - ST_W'(1);
    end else if (cand > current_r) begin
      step_st = current_r + ST_W'(1);
    end else begin
      step_st = current_r;
    end
  end

  assign use_wdata = (use_vld_r[AW'(st_r)] ? use_rdata : '0) + USAGE_W'(1);
  assign usage_rd  = ((mode_r == MODE_READ) && in_range(idx_r) && use_vld_r[AW'(idx_r)])
                     ? use_rdata : '0;

  // --------------------------------------------------------------- control
  always_comb begin
    state_nxt          = state_r;
    snapshot_valid_nxt = snapshot_valid_r;
    current_nxt        = current_r;
    pending_nxt        = pending_r;
    pending_valid_nxt  = pending_valid_r;
    thr_vld_nxt        = thr_vld_r;
    use_vld_nxt        = use_vld_r;
    cnt_nxt            = cnt_r;
    thr_we             = 1'b0;
    thr_re             = 1'b0;
    use_we             = 1'b0;
    use_re             = 1'b0;
    use_raddr          = AW'(idx_r);
    div_start          = 1'b0;
    out_load           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_tuser == MODE_TICK) ? ST_DELTA : ST_MISC;
        end
      end
      ST_MISC: begin
        state_nxt = ST_OUT;
        unique case (mode_r)
          MODE_TICK: ;
          MODE_OUTCOME: begin
            if (pending_valid_r && ok_r) begin
              current_nxt = pending_r;
            end
            pending_valid_nxt = 1'b0;
          end
          MODE_LOAD: begin
            if (in_range(idx_r)) begin
              thr_we                  = 1'b1;
              thr_vld_nxt[AW'(idx_r)] = 1'b1;
            end
          end
          MODE_READ: use_re = 1'b1;
        endcase
      end
      ST_DELTA: begin
        thr_re             = 1'b1;
        snapshot_valid_nxt = 1'b1;
        cnt_nxt            = '0;
        state_nxt          = (snapshot_valid_r && auto_r) ? ST_SUM : ST_DECIDE;
      end
      ST_SUM: begin
        cnt_nxt = cnt_r + CNT_IDX_W'(1);
        if (cnt_r == CNT_IDX_W'(NUM_CNT - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (step_st != current_r) begin
          pending_nxt       = step_st;
          pending_valid_nxt = 1'b1;
        end else begin
          pending_valid_nxt = 1'b0;
        end
        state_nxt = ST_URD;
      end
      ST_URD: begin
        use_re    = 1'b1;
        use_raddr = AW'(st_r);
        state_nxt = ST_UWR;
      end
      ST_UWR: begin
        if (in_range(st_r)) begin
          use_we                 = 1'b1;
          use_vld_nxt[AW'(st_r)] = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (mode_r == MODE_TICK) begin
      out_tdata_nxt = {{OUT_PAD{1'b0}}, {USAGE_W{1'b0}}, busy_r, change_r, st_r};
    end else begin
      out_tdata_nxt = {{OUT_PAD{1'b0}}, usage_rd, {PCT_W{1'b0}}, 1'b0, current_r};
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      snapshot_valid_r <= 1'b0;
      current_r        <= '0;
      pending_r        <= '0;
      pending_valid_r  <= 1'b0;
      thr_vld_r        <= '0;
      use_vld_r        <= '0;
      cnt_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      snapshot_valid_r <= snapshot_valid_nxt;
      current_r        <= current_nxt;
      pending_r        <= pending_nxt;
      pending_valid_r  <= pending_valid_nxt;
      thr_vld_r        <= thr_vld_nxt;
      use_vld_r        <= use_vld_nxt;
      cnt_r            <= cnt_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_tuser;
      for (int i = 0; i < NUM_CNT; i++) begin
        now_r[i] <= in_tdata[i*CNT_W +: CNT_W];
      end
      ok_r  <= in_tdata[NUM_CNT*CNT_W];
      idx_r <= in_tdata[NUM_CNT*CNT_W + 1 +: ST_W];
      val_r <= in_tdata[NUM_CNT*CNT_W + 1 + ST_W +: PCT_W];
    end
    if (state_r == ST_DELTA) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        delta_r[i] <= now_r[i] - prev_r[i];
        prev_r[i]  <= now_r[i];
      end
      acc_r  <= '0;
      busy_r <= '0;
      snap_r <= !snapshot_valid_r;
    end
    if (state_r == ST_SUM) begin
      acc_r <= acc_r + SUM_W'(delta_r[cnt_r]);
    end
    if (state_r == ST_DIV && div_done) begin
      busy_r <= (acc_r != '0) ? (PERCENT - div_q) : '0;
    end
    if (state_r == ST_DECIDE) begin
      st_r     <= step_st;
      change_r <= (step_st != current_r);
    end
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // A pending request always names a state other than the committed one.
  `PLG_ASSERT_IMP(a_pending_differs, pending_valid_r, pending_pstate_ok(pending_r, current_r))
  // The committed state only moves while an outcome request is handled.
  `PLG_ASSERT_NXT(a_commit_only_on_outcome, state_r != ST_MISC, $stable(current_r))
  // The idle share of a nonzero interval never exceeds the whole interval.
  `PLG_ASSERT_IMP(a_busy_quotient_range, div_done && (acc_r != '0), div_q <= PERCENT)

endmodule

[dv/pstate_load_governor_unit_tb.sv]
module pstate_load_governor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plg_pkg::*;

  localparam int PHASE_ITEMS = 220;
  localparam int NUM_PHASES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    pct_t                  val;
    logic [ST_W-1:0]       idx;
    logic                  ok;
    cnt_t [NUM_CNT-1:0]    cnt;
    logic [MODE_W-1:0]     mode;
  } gov_req_t;

  typedef struct packed {
    logic [USAGE_W-1:0] usage;
    pct_t               busy;
    logic               chg;
    pstate_t            tgt;
  } gov_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  pstate_load_governor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Governor settings as last written.
  logic    auto_mode    = AUTO_RST;
  pstate_t fixed_target = FIXED_RST;
  pstate_t top_state    = HIGHEST_RST;
  pstate_t bottom_state = LOWEST_RST;
  pct_t    raise_pct    = RAISE_RST;

  // Governor state.
  cnt_t [NUM_CNT-1:0] prev_cnt = '0;
  logic    snap_taken = 1'b0;
  pstate_t cur_state = '0;
  pstate_t req_state = '0;
  logic    req_live = 1'b0;
  pct_t    low_thresh [PLG_NUM_PSTATES] = '{default: '0};
  logic [USAGE_W-1:0] usage_cnt [PLG_NUM_PSTATES] = '{default: '0};

  gov_req_t pending_reqs[$];
  gov_res_t expected_results[$];
  gov_req_t on_bus;
  cnt_t [NUM_CNT-1:0] gen_cnt = '0;
  int reqs_queued = 0;
  int results_seen = 0;
  int err_count = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic gov_res_t govern(input gov_req_t r);
    gov_res_t res;
    logic [63:0] total, idle_d;
    cnt_t d;
    int busy, nxt;
    res = '0;
    busy = 0;
    nxt = int'(cur_state);
    case (r.mode)
      MODE_TICK: begin
        if (!snap_taken) begin
          snap_taken = 1'b1;
        end else if (auto_mode) begin
          total = '0;
          idle_d = '0;
          for (int k = 0; k < NUM_CNT; k++) begin
            d = r.cnt[k] - prev_cnt[k];
            total += 64'(d);
            if (k == IDLE_SLOT) idle_d = 64'(d);
          end
          if (total != 0) busy = int'(PERCENT) - int'(idle_d * 100 / total);
          if (busy > int'(raise_pct)) begin
            if (nxt > int'(top_state)) nxt--;
          end else if (nxt < int'(bottom_state)) begin
            if (busy <= int'(low_thresh[cur_state])) nxt++;
          end
        end else begin
          nxt = int'(fixed_target);
        end
        prev_cnt = r.cnt;
        if (nxt < int'(top_state)) nxt = int'(top_state);
        // Never more than one step away from the committed state.
        if (nxt != int'(cur_state)) begin
          nxt = (nxt < int'(cur_state)) ? int'(cur_state) - 1 : int'(cur_state) + 1;
        end
        res.tgt = nxt[ST_W-1:0];
        res.chg = (nxt != int'(cur_state));
        res.busy = busy[PCT_W-1:0];
        if (res.chg) begin
          req_state = nxt[ST_W-1:0];
          req_live = 1'b1;
        end else begin
          req_live = 1'b0;
        end
        usage_cnt[nxt[ST_W-1:0]] += 1;
      end
      MODE_OUTCOME: begin
        if (req_live && r.ok) cur_state = req_state;
        req_live = 1'b0;
        res.tgt = cur_state;
      end
      MODE_LOAD: begin
        low_thresh[r.idx] = r.val;
        res.tgt = cur_state;
      end
      default: begin
        res.usage = usage_cnt[r.idx];
        res.tgt = cur_state;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(govern(on_bus));
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_DATA_W'({on_bus.val, on_bus.idx, on_bus.ok, on_bus.cnt});
          in_tuser <= on_bus.mode;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    gov_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = gov_res_t'(out_tdata[$bits(gov_res_t)-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, actual %h",
                   $time, got);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("target_state", 32'(want.tgt), 32'(got.tgt));
          check_field("change_request", 32'(want.chg), 32'(got.chg));
          check_field("busy_percent", 32'(want.busy), 32'(got.busy));
          check_field("usage_count", want.usage, got.usage);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, reqs_queued - results_seen);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [REG_IDX_W-1:0] reg_idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_idx)
      REG_AUTO_ENABLE:     auto_mode = data[0];
      REG_FIXED_STATE:     fixed_target = data[ST_W-1:0];
      REG_HIGHEST_STATE:   top_state = data[ST_W-1:0];
      REG_LOWEST_STATE:    bottom_state = data[ST_W-1:0];
      REG_RAISE_THRESHOLD: raise_pct = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  // Upper bits carry junk that the block must drop.
  task automatic set_governor(input logic a, input pstate_t f, input pstate_t hi,
                              input pstate_t lo, input pct_t rp);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cfg_write(REG_AUTO_ENABLE, {junk[CFG_DATA_W-1:1], a});
    junk = $urandom;
    cfg_write(REG_FIXED_STATE, {junk[CFG_DATA_W-1:ST_W], f});
    junk = $urandom;
    cfg_write(REG_HIGHEST_STATE, {junk[CFG_DATA_W-1:ST_W], hi});
    junk = $urandom;
    cfg_write(REG_LOWEST_STATE, {junk[CFG_DATA_W-1:ST_W], lo});
    junk = $urandom;
    cfg_write(REG_RAISE_THRESHOLD, {junk[CFG_DATA_W-1:PCT_W], rp});
  endtask

  task automatic wait_drained();
    while (results_seen != reqs_queued) @(posedge clk);
  endtask

  function automatic gov_req_t noise_req(input logic [MODE_W-1:0] m);
    gov_req_t r;
    for (int k = 0; k < NUM_CNT; k++) r.cnt[k] = $urandom;
    r.ok = 1'($urandom_range(1));
    r.idx = ST_W'($urandom_range(PLG_NUM_PSTATES - 1));
    r.val = PCT_W'($urandom_range(127));
    r.mode = m;
    return r;
  endfunction

  task automatic queue_req(input gov_req_t r);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_tick(input cnt_t [NUM_CNT-1:0] c);
    gov_req_t r;
    r = noise_req(MODE_TICK);
    r.cnt = c;
    gen_cnt = c;
    queue_req(r);
  endtask

  task automatic queue_outcome(input logic ok);
    gov_req_t r;
    r = noise_req(MODE_OUTCOME);
    r.ok = ok;
    queue_req(r);
  endtask

  task automatic queue_load(input logic [ST_W-1:0] idx, input pct_t val);
    gov_req_t r;
    r = noise_req(MODE_LOAD);
    r.idx = idx;
    r.val = val;
    queue_req(r);
  endtask

  task automatic queue_read(input logic [ST_W-1:0] idx);
    gov_req_t r;
    r = noise_req(MODE_READ);
    r.idx = idx;
    queue_req(r);
  endtask

  // Advances the counters by deltas of a random scale, or at times sets them to random values,
  // so that busy spans the whole range and sums cross 2^32 now and then.
  task automatic queue_load_tick();
    cnt_t [NUM_CNT-1:0] c;
    cnt_t scale, bmax, imax;
    int sel;
    sel = $urandom_range(9);
    scale = (sel == 0) ? 32'd0 : (sel < 4) ? 32'd20 : (sel < 6) ? 32'd5000 :
            (sel < 8) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
    bmax = scale >> $urandom_range(6);
    imax = scale >> $urandom_range(6);
    if ($urandom_range(7) == 0) begin
      bmax = 0;
    end else if ($urandom_range(7) == 0) begin
      imax = 0;
    end
    for (int k = 0; k < NUM_CNT; k++)
      c[k] = gen_cnt[k] + ((k == IDLE_SLOT) ? $urandom_range(imax) : $urandom_range(bmax));
    if (sel == 9 && $urandom_range(1) == 1) begin
      for (int k = 0; k < NUM_CNT; k++) c[k] = $urandom;
    end
    queue_tick(c);
  endtask

  initial begin
    cnt_t [NUM_CNT-1:0] c;
    int n, pick;
    send_idle_pct = 18;
    recv_idle_pct = 61;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Counters near the top, then wrapping past zero.
    c = {NUM_CNT{32'hFFFF_FFFF}};
    queue_tick(c);
    c[0] = 32'd9;
    c[IDLE_SLOT] = 32'd4;
    queue_tick(c);
    // No time has passed at all: busy reads as zero and the state drops.
    queue_tick(c);
    queue_outcome(1'b1);
    queue_outcome(1'b1);
    c[0] += 50;
    queue_tick(c);
    queue_outcome(1'b0);
    queue_load(4'd1, 7'd100);
    queue_load(4'd15, 7'd127);
    queue_load(4'd0, 7'd50);
    c[1] += 25;
    c[IDLE_SLOT] += 25;
    queue_tick(c);
    queue_outcome(1'b1);
    c[2] += 60;
    c[IDLE_SLOT] += 40;
    queue_tick(c);
    // The tick above asked for nothing, so this outcome must not commit.
    queue_outcome(1'b1);
    queue_read(4'd0);
    queue_read(4'd1);
    queue_read(4'd2);
    queue_read(4'd15);
    for (int k = 0; k < NUM_CNT; k++) c[k] += 32'hFFFF_FFFF;
    queue_tick(c);
    c[3] += 99;
    c[IDLE_SLOT] += 1;
    queue_tick(c);
    queue_outcome(1'b1);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 18;
      end else if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_governor(1'b1, 4'd0, 4'd0, 4'd15, 7'd98);
        1: set_governor(1'b1, 4'd7, 4'd0, 4'd15, 7'd50);
        2: set_governor(1'b1, 4'd0, 4'd3, 4'd12, 7'd0);
        3: set_governor(1'b1, 4'd0, 4'd0, 4'd15, 7'd127);
        4: set_governor(1'b0, 4'd15, 4'd0, 4'd15, 7'd60);
        5: set_governor(1'b0, 4'd0, 4'd15, 4'd0, 7'd100);
        6: set_governor(1'b1, 4'd3, 4'd15, 4'd0, 7'd100);
        default: begin
          cfg_write(REG_UNUSED, $urandom);
          set_governor(1'($urandom_range(1)), ST_W'($urandom_range(15)),
                       ST_W'($urandom_range(15)), ST_W'($urandom_range(15)),
                       PCT_W'($urandom_range(127)));
        end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          queue_load_tick();
          n++;
          if ($urandom_range(9) < 7) begin
            queue_outcome($urandom_range(99) < 85);
            n++;
          end
        end else if (pick < 70) begin
          queue_load(ST_W'($urandom_range(PLG_NUM_PSTATES - 1)),
                     PCT_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                     : $urandom_range(100)));
          n++;
        end else if (pick < 80) begin
          queue_read(ST_W'($urandom_range(PLG_NUM_PSTATES - 1)));
          n++;
        end else begin
          queue_outcome(1'($urandom_range(1)));
          n++;
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/plg_pkg.sv
sv/plg_ram.sv
sv/plg_busy_div.sv
sv/pstate_load_governor_unit.sv
dv/pstate_load_governor_unit_tb.sv
